[design/vfg_pkg.sv]
// ----------------------------------------------------------------------------
// vfg_pkg
// shared types and constants of the voxel face visibility grid
// ----------------------------------------------------------------------------
package vfg_pkg;

    localparam int DIM_W   = 7;     // effective size, up to 63
    localparam int FA_W    = 20;    // full linear address before range check
    localparam int COORD_W = 6;
    localparam int CMDC_W  = 5;
    localparam int CNT_W   = 16;

    localparam logic [5:0] FULL_MASK = 6'd63;

    localparam logic       OP_ADD    = 1'b0;
    localparam logic       OP_REMOVE = 1'b1;

    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    // neighbour visiting order
    localparam logic [2:0] DIR_PX = 3'd0;
    localparam logic [2:0] DIR_PY = 3'd1;
    localparam logic [2:0] DIR_PZ = 3'd2;
    localparam logic [2:0] DIR_NX = 3'd3;
    localparam logic [2:0] DIR_NY = 3'd4;
    localparam logic [2:0] DIR_NZ = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_READ,
        ST_DATA,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0]  voxel_type;
        logic [31:0] color;
        logic [5:0]  mask;
    } cell_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [CMDC_W-1:0] x;
        logic [CMDC_W-1:0] y;
        logic [CMDC_W-1:0] z;
        logic [31:0]       color;
        logic              ok;
        logic [CNT_W-1:0]  count;
        logic              last;
    } res_t;

    // face of the neighbour that looks back at the centre cell
    function automatic logic [5:0] facing_bit(input logic [2:0] dir);
        logic [5:0] b;
        case (dir)
            DIR_PX:  b = 6'b000010;
            DIR_PY:  b = 6'b001000;
            DIR_PZ:  b = 6'b100000;
            DIR_NX:  b = 6'b000001;
            DIR_NY:  b = 6'b000100;
            DIR_NZ:  b = 6'b010000;
            default: b = 6'b000000;
        endcase
        return b;
    endfunction

endpackage

[design/vfg_cell_ram.sv]
// ----------------------------------------------------------------------------
// vfg_cell_ram
// single-port cell store, one access per cycle, registered read data
// ----------------------------------------------------------------------------
module vfg_cell_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic                 re,
    input  logic [AW-1:0]        addr,
    input  vfg_pkg::cell_t       wdata,
    output vfg_pkg::cell_t       rdata
);

    vfg_pkg::cell_t cell_mem [DEPTH];
    vfg_pkg::cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cell_mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= cell_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/voxel_face_visibility_grid_unit.sv]
// ----------------------------------------------------------------------------
// voxel_face_visibility_grid_unit
// voxel grid with per-face culling, emitting render add and remove beats
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole cell store (CELL_COUNT cells, 32768
// by default), one cell a cycle, before it takes its first item.
// One item at a time: ST_IDLE, ST_MUL and ST_ADDR take the item and form the
// address; each in-bounds cell (centre and each neighbour) then gets a read and
// then a write-back on the single memory port, an out-of-bounds neighbour is
// skipped in ST_READ, and ST_FINISH closes the item. A failing item goes to
// ST_FINISH from ST_ADDR or after the centre read. Result beats leave through
// an output register and may stall the sequence when it is full.
module voxel_face_visibility_grid_unit #(
    parameter int MAX_DIM    = 32,
    parameter int CELL_COUNT = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [5:0]  pos_x,
    input  logic [5:0]  pos_y,
    input  logic [5:0]  pos_z,
    input  logic [7:0]  voxel_type,
    input  logic [31:0] voxel_color,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  command,
    output logic [4:0]  cmd_x,
    output logic [4:0]  cmd_y,
    output logic [4:0]  cmd_z,
    output logic [31:0] cmd_color,
    output logic        succeeded,
    output logic [15:0] occupied_count,
    output logic        last
);

    localparam int AW = $clog2(CELL_COUNT);
    localparam logic [vfg_pkg::FA_W-1:0]  CELL_LIM = vfg_pkg::FA_W'(CELL_COUNT);
    localparam logic [AW-1:0]             CLR_LAST = AW'(CELL_COUNT - 1);
    localparam logic [vfg_pkg::DIM_W-1:0] DIM_MAX  = vfg_pkg::DIM_W'(MAX_DIM);

    localparam int DW = vfg_pkg::DIM_W;
    localparam int FW = vfg_pkg::FA_W;
    localparam int CW = vfg_pkg::COORD_W;

    vfg_pkg::state_t state_reg, state_next;

    logic [5:0] width_reg, height_reg, length_reg;
    logic [DW-1:0] w_eff, h_eff, l_eff;

    logic          op_reg, op_next;
    logic [CW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [7:0]    vtype_reg, vtype_next;
    logic [31:0]   vcolor_reg, vcolor_next;

    logic [FW-1:0] t_reg, t_next, wh_reg, wh_next, ca_reg, ca_next;
    logic [FW-1:0] cur_addr_reg, cur_addr_next;
    logic          bnd_reg, bnd_next;
    logic          center_reg, center_next;
    logic [2:0]    dir_reg, dir_next;
    logic [CW-1:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [15:0]   count_reg, count_next;

    vfg_pkg::res_t pend_reg, pend_next, out_reg, out_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_addr;
    vfg_pkg::cell_t ram_wdata, ram_rdata;

    logic          out_free;
    logic          nb_ok;
    logic [FW-1:0] nb_addr, ca_calc;
    logic [CW-1:0] nx, ny, nz;
    logic          cell_fail, emit, go;
    vfg_pkg::cell_t new_cell;
    vfg_pkg::res_t  res;

    vfg_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        w_eff = ({1'b0, width_reg}  > DIM_MAX) ? DIM_MAX : {1'b0, width_reg};
        h_eff = ({1'b0, height_reg} > DIM_MAX) ? DIM_MAX : {1'b0, height_reg};
        l_eff = ({1'b0, length_reg} > DIM_MAX) ? DIM_MAX : {1'b0, length_reg};
    end

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 6'd32;
            height_reg <= 6'd32;
            length_reg <= 6'd32;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                vfg_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                vfg_pkg::REG_HEIGHT: height_reg <= cfg_data;
                vfg_pkg::REG_LENGTH: length_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vfg_pkg::ST_CLEAR;
            clr_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            center_reg     <= 1'b0;
            dir_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            center_reg     <= center_next;
            dir_reg        <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        vtype_reg    <= vtype_next;
        vcolor_reg   <= vcolor_next;
        t_reg        <= t_next;
        wh_reg       <= wh_next;
        ca_reg       <= ca_next;
        bnd_reg      <= bnd_next;
        cur_addr_reg <= cur_addr_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    // neighbour address and bounds from the centre address
    always_comb
    begin
        nx      = x_reg;
        ny      = y_reg;
        nz      = z_reg;
        nb_addr = ca_reg;
        nb_ok   = 1'b0;
        case (dir_reg)
            vfg_pkg::DIR_PX:
            begin
                nx      = x_reg + 1'b1;
                nb_ok   = (DW'(x_reg) + 1'b1) < w_eff;
                nb_addr = ca_reg + 1'b1;
            end
            vfg_pkg::DIR_PY:
            begin
                ny      = y_reg + 1'b1;
                nb_ok   = (DW'(y_reg) + 1'b1) < h_eff;
                nb_addr = ca_reg + FW'(w_eff);
            end
            vfg_pkg::DIR_PZ:
            begin
                nz      = z_reg + 1'b1;
                nb_ok   = (DW'(z_reg) + 1'b1) < l_eff;
                nb_addr = ca_reg + wh_reg;
            end
            vfg_pkg::DIR_NX:
            begin
                nx      = x_reg - 1'b1;
                nb_ok   = x_reg != '0;
                nb_addr = ca_reg - 1'b1;
            end
            vfg_pkg::DIR_NY:
            begin
                ny      = y_reg - 1'b1;
                nb_ok   = y_reg != '0;
                nb_addr = ca_reg - FW'(w_eff);
            end
            vfg_pkg::DIR_NZ:
            begin
                nz      = z_reg - 1'b1;
                nb_ok   = z_reg != '0;
                nb_addr = ca_reg - wh_reg;
            end
            default: ;
        endcase
        if (center_reg)
        begin
            nx      = x_reg;
            ny      = y_reg;
            nz      = z_reg;
            nb_addr = ca_reg;
            nb_ok   = 1'b1;
        end
        else
        begin
            nb_ok = nb_ok && (nb_addr < CELL_LIM);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        center_next     = center_reg;
        dir_next        = dir_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        vtype_next      = vtype_reg;
        vcolor_next     = vcolor_reg;
        t_next          = t_reg;
        wh_next         = wh_reg;
        ca_next         = ca_reg;
        bnd_next        = bnd_reg;
        cur_addr_next   = cur_addr_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;

        out_free       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = cur_addr_reg[AW-1:0];
        ram_wdata = ram_rdata;

        ca_calc = FW'((t_reg + FW'(y_reg)) * FW'(w_eff)) + FW'(x_reg);

        cell_fail = 1'b0;
        emit      = 1'b0;
        go        = 1'b1;
        new_cell  = ram_rdata;
        res       = '0;
        res.ok    = 1'b1;
        res.x     = cx_reg[vfg_pkg::CMDC_W-1:0];
        res.y     = cy_reg[vfg_pkg::CMDC_W-1:0];
        res.z     = cz_reg[vfg_pkg::CMDC_W-1:0];
        res.count = count_reg;

        in_stall = (state_reg != vfg_pkg::ST_IDLE);

        case (state_reg)
            vfg_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '{voxel_type: 8'd0, color: 32'd0, mask: vfg_pkg::FULL_MASK};
                if (clr_reg == CLR_LAST)
                begin
                    state_next = vfg_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            vfg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = op;
                    x_next      = pos_x;
                    y_next      = pos_y;
                    z_next      = pos_z;
                    vtype_next  = voxel_type;
                    vcolor_next = voxel_color;
                    state_next  = vfg_pkg::ST_MUL;
                end
            end
            vfg_pkg::ST_MUL:
            begin
                t_next     = FW'(z_reg) * FW'(h_eff);
                wh_next    = FW'(w_eff) * FW'(h_eff);
                bnd_next   = (DW'(x_reg) < w_eff) && (DW'(y_reg) < h_eff)
                             && (DW'(z_reg) < l_eff);
                state_next = vfg_pkg::ST_ADDR;
            end
            vfg_pkg::ST_ADDR:
            begin
                ca_next = ca_calc;
                if (bnd_reg && (ca_calc < CELL_LIM))
                begin
                    center_next = 1'b1;
                    state_next  = vfg_pkg::ST_READ;
                end
                else
                begin
                    pend_next       = '0;
                    pend_next.count = count_reg;
                    pend_valid_next = 1'b1;
                    state_next      = vfg_pkg::ST_FINISH;
                end
            end
            vfg_pkg::ST_READ:
            begin
                if (nb_ok)
                begin
                    ram_re        = 1'b1;
                    ram_addr      = nb_addr[AW-1:0];
                    cur_addr_next = nb_addr;
                    cx_next       = nx;
                    cy_next       = ny;
                    cz_next       = nz;
                    state_next    = vfg_pkg::ST_DATA;
                end
                else if (dir_reg == vfg_pkg::DIR_NZ)
                begin
                    state_next = vfg_pkg::ST_FINISH;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                end
            end
            vfg_pkg::ST_DATA:
            begin
                if (center_reg)
                begin
                    if (op_reg == vfg_pkg::OP_ADD)
                    begin
                        cell_fail = (ram_rdata.voxel_type != 8'd0) || (vtype_reg == 8'd0);
                        new_cell.voxel_type = vtype_reg;
                        new_cell.color      = vcolor_reg;
                        emit                = 1'b1;
                        res.command         = vfg_pkg::CMD_ADD;
                        res.color           = vcolor_reg;
                        res.count = (count_reg != 16'hFFFF) ? count_reg + 1'b1 : count_reg;
                    end
                    else
                    begin
                        cell_fail = (ram_rdata.voxel_type == 8'd0);
                        new_cell.voxel_type = 8'd0;
                        emit                = (ram_rdata.mask != 6'd0);
                        res.command         = vfg_pkg::CMD_REMOVE;
                        res.count = (count_reg != 16'd0) ? count_reg - 1'b1 : count_reg;
                    end
                    if (cell_fail)
                    begin
                        pend_next       = '0;
                        pend_next.count = count_reg;
                        pend_valid_next = 1'b1;
                        state_next      = vfg_pkg::ST_FINISH;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        ram_wdata   = new_cell;
                        count_next  = res.count;
                        center_next = 1'b0;
                        dir_next    = vfg_pkg::DIR_PX;
                        state_next  = vfg_pkg::ST_READ;
                        if (emit)
                        begin
                            pend_next       = res;
                            pend_valid_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (op_reg == vfg_pkg::OP_ADD)
                    begin
                        new_cell.mask = ram_rdata.mask & ~vfg_pkg::facing_bit(dir_reg);
                        emit = (ram_rdata.voxel_type != 8'd0) && (new_cell.mask == 6'd0);
                        res.command = vfg_pkg::CMD_REMOVE;
                    end
                    else
                    begin
                        new_cell.mask = ram_rdata.mask | vfg_pkg::facing_bit(dir_reg);
                        emit        = (ram_rdata.voxel_type != 8'd0);
                        res.command = vfg_pkg::CMD_ADD;
                        res.color   = ram_rdata.color;
                    end
                    // an earlier beat still waits for the output register
                    go = !(emit && pend_valid_reg && !out_free);
                    if (go)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = new_cell;
                        if (emit)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_next       = pend_reg;
                                out_valid_next = 1'b1;
                            end
                            pend_next       = res;
                            pend_valid_next = 1'b1;
                        end
                        if (dir_reg == vfg_pkg::DIR_NZ)
                        begin
                            state_next = vfg_pkg::ST_FINISH;
                        end
                        else
                        begin
                            dir_next   = dir_reg + 1'b1;
                            state_next = vfg_pkg::ST_READ;
                        end
                    end
                end
            end
            vfg_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        // successful remove with nothing to draw
                        out_next       = '0;
                        out_next.ok    = 1'b1;
                        out_next.count = count_reg;
                    end
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = vfg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vfg_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign command        = out_reg.command;
    assign cmd_x          = out_reg.x;
    assign cmd_y          = out_reg.y;
    assign cmd_z          = out_reg.z;
    assign cmd_color      = out_reg.color;
    assign succeeded      = out_reg.ok;
    assign occupied_count = out_reg.count;
    assign last           = out_reg.last;

endmodule
